>>> src/svs_pkg.sv
// ----------------------------------------------------------------------------
// Sorted value stack package
// Shared constants, operation and status codes, and sequencer states for the
// sorted value stack.
// ----------------------------------------------------------------------------
package svs_pkg;

  // Default sizes for the top-level parameters.
  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed widths of the operation and status codes.
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  // Operation codes carried on the request side.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELNEG = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  // Completion status codes carried on the result side.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DELNEG,
    S_READ,
    S_DONE
  } state_t;

endpackage

>>> src/sorted_value_stack_top.sv
// ----------------------------------------------------------------------------
// Sorted value stack
// Bounded ordered store of signed values with the top at position 0. Supports
// push, sorted insert, delete of negative entries, indexed read and clear.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid / s_tready  tuser: op; tdata: value, position
// m_*      out  m_tvalid / m_tready  tuser: status; tdata: count, read_value,
//                                    removed
//
// Entries live in one RAM with one read and one write port, and a small
// sequencer walks it one entry per cycle. Push, delete negatives and sorted
// insert walk the stored entries, the RAM port being the limit.
// A finished result waits in the output register while the next request is
// taken. Reset empties the store; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_value_stack_top #(
  parameter int DEPTH       = svs_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH  = svs_pkg::DATA_WIDTH_DEF,
  localparam int POS_W      = $clog2(DEPTH),
  localparam int CNT_W      = $clog2(DEPTH + 1),
  localparam int S_TDATA_W  = ((DATA_WIDTH + POS_W + 7) / 8) * 8,
  localparam int M_TDATA_W  = ((CNT_W + DATA_WIDTH + CNT_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [S_TDATA_W-1:0]          s_tdata,  // value, position
  input  logic [svs_pkg::OP_W-1:0]      s_tuser,  // op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [M_TDATA_W-1:0]          m_tdata,  // count, read_value, removed
  output logic [svs_pkg::STATUS_W-1:0]  m_tuser   // status
);

  // Request fields.
  logic [DATA_WIDTH-1:0] in_value;
  logic [POS_W-1:0]      in_position;
  svs_pkg::op_t          in_op;

  assign in_value    = s_tdata[DATA_WIDTH-1:0];
  assign in_position = s_tdata[DATA_WIDTH +: POS_W];
  assign in_op       = svs_pkg::op_t'(s_tuser);

  // Sequencer and store state.
  svs_pkg::state_t       state, state_next;
  logic [CNT_W-1:0]      fill, fill_next;
  logic [CNT_W-1:0]      idx, idx_next;
  logic [CNT_W-1:0]      kpos, kpos_next;
  logic [CNT_W-1:0]      wr_addr, wr_addr_next;
  logic                  chk, chk_next;
  logic                  wr_pend, wr_pend_next;
  logic [DATA_WIDTH-1:0] value_r, value_r_next;

  // Result being built and the output register.
  svs_pkg::status_t      res_status, res_status_next;
  logic [DATA_WIDTH-1:0] res_rd, res_rd_next;
  logic [CNT_W-1:0]      res_removed, res_removed_next;
  logic                  m_tvalid_next;
  svs_pkg::status_t      out_status, out_status_next;
  logic [CNT_W-1:0]      out_count, out_count_next;
  logic [DATA_WIDTH-1:0] out_rd, out_rd_next;
  logic [CNT_W-1:0]      out_removed, out_removed_next;

  // RAM port signals.
  logic                  ram_we;
  logic [POS_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [POS_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [CNT_W-1:0]      idx_dec;
  logic                  full;
  logic                  rd_less;

  assign idx_dec = idx - 1'b1;
  assign full    = (fill == CNT_W'(DEPTH));
  // Signed compare: the entry just read is smaller than the held value.
  assign rd_less = $signed(ram_rdata) < $signed(value_r);

  svs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= svs_pkg::S_IDLE;
      fill     <= '0;
      chk      <= 1'b0;
      wr_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      fill     <= fill_next;
      chk      <= chk_next;
      wr_pend  <= wr_pend_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx         <= idx_next;
    kpos        <= kpos_next;
    wr_addr     <= wr_addr_next;
    value_r     <= value_r_next;
    res_status  <= res_status_next;
    res_rd      <= res_rd_next;
    res_removed <= res_removed_next;
    out_status  <= out_status_next;
    out_count   <= out_count_next;
    out_rd      <= out_rd_next;
    out_removed <= out_removed_next;
  end

  // Sequencer: next state, RAM control and result building.
  always_comb begin
    state_next       = state;
    fill_next        = fill;
    idx_next         = idx;
    kpos_next        = kpos;
    wr_addr_next     = wr_addr;
    chk_next         = chk;
    wr_pend_next     = wr_pend;
    value_r_next     = value_r;
    res_status_next  = res_status;
    res_rd_next      = res_rd;
    res_removed_next = res_removed;
    out_status_next  = out_status;
    out_count_next   = out_count;
    out_rd_next      = out_rd;
    out_removed_next = out_removed;
    ram_we           = 1'b0;
    ram_waddr        = '0;
    ram_wdata        = ram_rdata;
    ram_raddr        = '0;
    s_tready         = (state == svs_pkg::S_IDLE);

    // The output register empties when the result is taken.
    m_tvalid_next = m_tvalid && !m_tready;

    unique case (state)
      svs_pkg::S_IDLE: begin
        if (s_tvalid) begin
          value_r_next     = in_value;
          res_status_next  = svs_pkg::ST_OK;
          res_rd_next      = '0;
          res_removed_next = '0;
          chk_next         = 1'b0;
          wr_pend_next     = 1'b0;
          idx_next         = '0;
          kpos_next        = '0;
          state_next       = svs_pkg::S_DONE;
          unique case (in_op)
            svs_pkg::OP_PUSH: begin
              if (full) begin
                res_status_next = svs_pkg::ST_FULL;
              end else begin
                idx_next   = fill;
                state_next = svs_pkg::S_SHIFT;
              end
            end
            svs_pkg::OP_INSERT: begin
              if (full) begin
                res_status_next = svs_pkg::ST_FULL;
              end else begin
                state_next = svs_pkg::S_SCAN;
              end
            end
            svs_pkg::OP_DELNEG: begin
              state_next = svs_pkg::S_DELNEG;
            end
            svs_pkg::OP_READ: begin
              if (CNT_W'(in_position) >= fill) begin
                res_status_next = svs_pkg::ST_RANGE;
              end else begin
                ram_raddr  = in_position;
                state_next = svs_pkg::S_READ;
              end
            end
            svs_pkg::OP_CLEAR: begin
              res_removed_next = fill;
              fill_next        = '0;
            end
            default: begin
              // Unused codes leave the store alone and report ok.
            end
          endcase
        end
      end

      svs_pkg::S_SCAN: begin
        // Walk from the top until an entry smaller than the value shows up.
        if (chk && rd_less) begin
          kpos_next    = idx_dec;
          idx_next     = fill;
          chk_next     = 1'b0;
          wr_pend_next = 1'b0;
          state_next   = svs_pkg::S_SHIFT;
        end else if (idx == fill) begin
          kpos_next    = fill;
          chk_next     = 1'b0;
          wr_pend_next = 1'b0;
          state_next   = svs_pkg::S_SHIFT;
        end else begin
          ram_raddr = idx[POS_W-1:0];
          chk_next  = 1'b1;
          idx_next  = idx + 1'b1;
        end
      end

      svs_pkg::S_SHIFT: begin
        // Move entries down one slot from the bottom, then drop the value in.
        if (wr_pend) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr[POS_W-1:0];
          ram_wdata = ram_rdata;
        end
        if (idx > kpos) begin
          ram_raddr    = idx_dec[POS_W-1:0];
          wr_pend_next = 1'b1;
          wr_addr_next = idx;
          idx_next     = idx_dec;
        end else if (wr_pend) begin
          wr_pend_next = 1'b0;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = kpos[POS_W-1:0];
          ram_wdata  = value_r;
          fill_next  = fill + 1'b1;
          state_next = svs_pkg::S_DONE;
        end
      end

      svs_pkg::S_DELNEG: begin
        // Compact the non-negative entries toward the top in order.
        if (chk && !ram_rdata[DATA_WIDTH-1]) begin
          ram_we    = 1'b1;
          ram_waddr = kpos[POS_W-1:0];
          ram_wdata = ram_rdata;
          kpos_next = kpos + 1'b1;
        end
        if (idx < fill) begin
          ram_raddr = idx[POS_W-1:0];
          chk_next  = 1'b1;
          idx_next  = idx + 1'b1;
        end else if (chk) begin
          chk_next = 1'b0;
        end else begin
          res_removed_next = fill - kpos;
          fill_next        = kpos;
          state_next       = svs_pkg::S_DONE;
        end
      end

      svs_pkg::S_READ: begin
        res_rd_next = ram_rdata;
        state_next  = svs_pkg::S_DONE;
      end

      svs_pkg::S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!m_tvalid || m_tready) begin
          m_tvalid_next    = 1'b1;
          out_status_next  = res_status;
          out_count_next   = fill;
          out_rd_next      = res_rd;
          out_removed_next = res_removed;
          state_next       = svs_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = svs_pkg::S_IDLE;
      end
    endcase
  end

  // Result payload.
  assign m_tuser = out_status;
  assign m_tdata = M_TDATA_W'({out_removed, out_rd, out_count});

endmodule

>>> src/svs_ram.sv
// ----------------------------------------------------------------------------
// Sorted value stack RAM
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module svs_ram #(
  parameter int WIDTH = svs_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = svs_pkg::DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> test/sorted_value_stack_top_test.sv
// ----------------------------------------------------------------------------
// Sorted value stack testbench
// Drives push, sorted insert, delete-negatives, read, clear and unused codes
// into the stack with random gaps and output stalls. A mirror of the stack
// predicts every result, and each returned result is compared field by field.
// ----------------------------------------------------------------------------
module sorted_value_stack_top_test;

  localparam int DEPTH     = svs_pkg::DEPTH_DEF;
  localparam int DATA_W    = svs_pkg::DATA_WIDTH_DEF;
  localparam int OP_W      = svs_pkg::OP_W;
  localparam int STATUS_W  = svs_pkg::STATUS_W;
  localparam int POS_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int S_TDATA_W = ((DATA_W + POS_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((CNT_W + DATA_W + CNT_W + 7) / 8) * 8;

  // Codes 5 to 7 are not operations; the stack must ignore them.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  localparam int RANDOM_ITEMS  = 1400;
  localparam int QUIET_ITEMS   = 200;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    svs_pkg::status_t         status;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         removed;
  } stack_result_t;

  // Mirror of the stack contents and the queue of results it predicts.
  class stack_mirror;
    logic signed [DATA_W-1:0] entries [DEPTH];
    int                       fill;
    stack_result_t            pending_results [$];
    int                       errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // Apply one accepted request to the mirror and queue its result.
    function void note_request(logic [OP_W-1:0] op_code,
                               logic signed [DATA_W-1:0] value,
                               logic [POS_W-1:0] pos);
      stack_result_t res;
      int            slot;
      int            kept;
      int            i;
      res = '{status: svs_pkg::ST_OK, count: '0, read_value: '0, removed: '0};
      case (op_code) inside
        svs_pkg::OP_PUSH, svs_pkg::OP_INSERT: begin
          if (fill >= DEPTH) begin
            res.status = svs_pkg::ST_FULL;
          end else begin
            slot = 0;
            // Sorted insert goes in front of the first smaller entry.
            if (op_code == svs_pkg::OP_INSERT) begin
              while (slot < fill && !(entries[slot] < value)) slot++;
            end
            for (i = fill; i > slot; i--) entries[i] = entries[i-1];
            entries[slot] = value;
            fill++;
          end
        end
        svs_pkg::OP_DELNEG: begin
          kept = 0;
          for (i = 0; i < fill; i++) begin
            if (entries[i] >= 0) begin
              entries[kept] = entries[i];
              kept++;
            end
          end
          res.removed = CNT_W'(fill - kept);
          fill = kept;
        end
        svs_pkg::OP_READ: begin
          if (int'(pos) >= fill) res.status = svs_pkg::ST_RANGE;
          else res.read_value = entries[pos];
        end
        svs_pkg::OP_CLEAR: begin
          res.removed = CNT_W'(fill);
          fill = 0;
        end
        default: begin
        end
      endcase
      res.count = CNT_W'(fill);
      pending_results.push_back(res);
    endfunction

    // Compare one returned result with the oldest prediction.
    function void check_result(stack_result_t got);
      stack_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $display("unexpected result: status %0d count %0d read_value %0d removed %0d",
                   got.status, got.count, got.read_value, got.removed);
        end
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status || got.count != want.count ||
            got.read_value != want.read_value || got.removed != want.removed) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("result mismatch: expected status %0d count %0d read_value %0d removed %0d",
                     want.status, want.count, want.read_value, want.removed);
            $display("                 got      status %0d count %0d read_value %0d removed %0d",
                     got.status, got.count, got.read_value, got.removed);
          end
        end
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;   // value, position
  logic [OP_W-1:0]        s_tuser = '0;   // op
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;        // count, read_value, removed
  logic [STATUS_W-1:0]    m_tuser;        // status

  stack_mirror mirror = new();
  bit          idling_on = 1'b1;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  sorted_value_stack_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Output side: ready, with random stall bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watch both handshakes, feed the mirror and guard against a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        mirror.note_request(s_tuser, s_tdata[DATA_W-1:0], s_tdata[DATA_W +: POS_W]);
      end
      if (m_tvalid && m_tready) begin
        mirror.check_result('{status: svs_pkg::status_t'(m_tuser),
                              count: m_tdata[CNT_W-1:0],
                              read_value: m_tdata[CNT_W +: DATA_W],
                              removed: m_tdata[CNT_W + DATA_W +: CNT_W]});
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("sorted_value_stack_top test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one request and hold it until the stack takes it.
  task automatic send_request(input logic [OP_W-1:0] op_code,
                              input logic [DATA_W-1:0] value,
                              input logic [POS_W-1:0] pos);
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op_code;
    s_tdata  <= S_TDATA_W'({pos, value});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Mostly small values so that equal keys and sign changes happen often.
  function automatic logic [DATA_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      case ($urandom_range(0, 3))
        0: return {1'b0, {(DATA_W-1){1'b1}}};
        1: return {1'b1, {(DATA_W-1){1'b0}}};
        2: return '0;
        default: return '1;
      endcase
    end else if (roll <= 3) begin
      return DATA_W'($urandom_range(0, 16)) - DATA_W'(8);
    end else if (roll <= 5) begin
      return DATA_W'($urandom);
    end
    return DATA_W'($urandom_range(0, 2000)) - DATA_W'(1000);
  endfunction

  // Growing runs fill the stack; mixed runs read, prune and clear it.
  function automatic logic [OP_W-1:0] pick_op(bit grow);
    int roll;
    roll = $urandom_range(0, 99);
    if (grow) begin
      if (roll < 35) return svs_pkg::OP_PUSH;
      if (roll < 80) return svs_pkg::OP_INSERT;
      if (roll < 90) return svs_pkg::OP_READ;
      if (roll < 95) return svs_pkg::OP_DELNEG;
      if (roll < 97) return svs_pkg::OP_CLEAR;
    end else begin
      if (roll < 20) return svs_pkg::OP_PUSH;
      if (roll < 45) return svs_pkg::OP_INSERT;
      if (roll < 75) return svs_pkg::OP_READ;
      if (roll < 87) return svs_pkg::OP_DELNEG;
      if (roll < 92) return svs_pkg::OP_CLEAR;
    end
    return OP_OP_UNUSED_PICK();
  endfunction

  function automatic logic [OP_W-1:0] OP_OP_UNUSED_PICK();
    return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
  endfunction

  initial begin
    int          done_items;
    int          run_left;
    int          i;
    bit          grow;
    logic [OP_W-1:0]  op_code;
    logic [POS_W-1:0] pos;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty store, unused codes, fill to the brim with extremes
    // and equal keys, then full-store drops, a deep read, prune and clear.
    send_request(svs_pkg::OP_CLEAR, '0, '0);
    send_request(svs_pkg::OP_DELNEG, '0, '0);
    send_request(svs_pkg::OP_READ, '0, '0);
    send_request(OP_UNUSED_LO, 32'h1234_5678, 4'hF);
    send_request(OP_UNUSED_HI, 32'hFFFF_FFFF, 4'h0);
    send_request(svs_pkg::OP_PUSH, 32'h7FFF_FFFF, '0);
    send_request(svs_pkg::OP_PUSH, 32'h8000_0000, '0);
    send_request(svs_pkg::OP_INSERT, 32'h0000_0000, '0);
    send_request(svs_pkg::OP_INSERT, 32'h0000_0000, '0);
    send_request(svs_pkg::OP_INSERT, 32'hFFFF_FFFF, '0);
    send_request(svs_pkg::OP_INSERT, 32'h7FFF_FFFF, '0);
    send_request(svs_pkg::OP_INSERT, 32'h8000_0000, '0);
    for (i = 0; i < DEPTH - 7; i++) begin
      send_request((i % 2 == 0) ? svs_pkg::OP_INSERT : svs_pkg::OP_PUSH, pick_value(), '0);
    end
    send_request(svs_pkg::OP_PUSH, 32'h5555_5555, '0);
    send_request(svs_pkg::OP_INSERT, 32'hAAAA_AAAA, '0);
    send_request(svs_pkg::OP_READ, '0, 4'hF);
    send_request(svs_pkg::OP_DELNEG, '0, '0);
    send_request(svs_pkg::OP_READ, '0, 4'h0);
    send_request(svs_pkg::OP_CLEAR, '0, '0);

    // Random runs; the final stretch has no idling on either side.
    done_items = 0;
    run_left   = 0;
    grow       = 1'b1;
    while (done_items < RANDOM_ITEMS) begin
      if (run_left == 0) begin
        grow     = ($urandom_range(0, 2) != 0);
        run_left = $urandom_range(8, 40);
      end
      run_left--;
      if (done_items >= RANDOM_ITEMS - QUIET_ITEMS) idling_on = 1'b0;
      op_code = pick_op(grow);
      if ($urandom_range(0, 3) != 0) begin
        pos = POS_W'($urandom_range(0, (mirror.fill < DEPTH - 1) ? mirror.fill : DEPTH - 1));
      end else begin
        pos = POS_W'($urandom);
      end
      send_request(op_code, pick_value(), pos);
      if (op_code < OP_UNUSED_LO) done_items++;
    end
    s_tvalid <= 1'b0;

    // Let the monitor record the last request before waiting on results.
    @(posedge clk);
    while (mirror.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.pending_results.size() == 0) begin
      $display("sorted_value_stack_top test passed");
    end else begin
      $display("sorted_value_stack_top test failed");
    end
    $finish;
  end

endmodule
